// ===== rtl/sspf_pkg.sv =====
// Shared types and constants of the SPI slave packet framer.
`timescale 1ns / 1ps
`default_nettype none

package sspf_pkg;

  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned TYPE_W         = 3;
  localparam int unsigned LEN_W          = 5;
  localparam int unsigned DEF_FIFO_DEPTH = 64;
  localparam logic [BYTE_W-1:0] CMD_BYTE_RESET = 8'hFF;

  typedef enum logic [1:0] {
    OP_SPI  = 2'd0,
    OP_HDR  = 2'd1,
    OP_DATA = 2'd2,
    OP_READ = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_PARTIAL = 2'd2,
    ST_REJECT  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_SEND = 2'd1,
    MODE_RECV = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_FETCH  = 2'd1,
    S_EXEC   = 2'd2,
    S_STREAM = 2'd3
  } state_e;

  typedef struct packed {
    op_e               opcode;
    logic [BYTE_W-1:0] mosi_byte;
    logic [BYTE_W-1:0] data_byte;
    logic [TYPE_W-1:0] pkt_type_in;
    logic [LEN_W-1:0]  pkt_len_in;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] miso_byte;
    status_e           status;
    logic [TYPE_W-1:0] pkt_type;
    logic [LEN_W-1:0]  pkt_len;
    logic [BYTE_W-1:0] rx_byte;
    logic              rx_byte_valid;
    logic              rx_dropped;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic stream;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic stream_start;
    logic stream_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/spi_slave_packet_framer.sv =====
// Top level of the SPI slave packet framer.
`timescale 1ns / 1ps
`default_nettype none

// SPI slave packet framer: length-prefixed packets (type in header bits 7:5,
// payload length in 4:0) pass through a transmit and a receive byte FIFO of
// FIFO_DEPTH entries each. One input word is handled at a time: it is taken,
// the FIFO heads are read from the registered store ports in the next cycle,
// and the result is formed in S_EXEC once the output register is free, then
// enters the output register. A host packet read gives its header result and
// then one payload result per cycle while the output register is free. A new
// input word is taken as soon as the previous one has placed its last result
// in the output register, while that result waits for the consumer. The
// command byte register resets to 0xFF and is written directly through
// cfg_we_i and cfg_wdata_i; the user must write it only while idle, as the
// block itself does not enforce this.

module spi_slave_packet_framer #(
  parameter int unsigned FIFO_DEPTH = sspf_pkg::DEF_FIFO_DEPTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire sspf_pkg::in_item_t            in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output sspf_pkg::out_item_t                out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [sspf_pkg::BYTE_W-1:0]   cfg_wdata_i
);

  sspf_pkg::ctrl_cmd_t cmd;
  sspf_pkg::dp_stat_t  stat;

  sspf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sspf_dp #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== rtl/sspf_ctrl.sv =====
// Sequencing state machine of the SPI slave packet framer.
`timescale 1ns / 1ps
`default_nettype none

module sspf_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire sspf_pkg::dp_stat_t  stat_i,
  output sspf_pkg::ctrl_cmd_t      cmd_o
);

  sspf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sspf_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      sspf_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = sspf_pkg::S_FETCH;
        end
      end
      // registered store reads settle on the current pointers
      sspf_pkg::S_FETCH: begin
        state_d = sspf_pkg::S_EXEC;
      end
      sspf_pkg::S_EXEC: begin
        if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = stat_i.stream_start ? sspf_pkg::S_STREAM : sspf_pkg::S_IDLE;
        end
      end
      sspf_pkg::S_STREAM: begin
        if (stat_i.out_free) begin
          cmd_o.stream = 1'b1;
          if (stat_i.stream_last) begin
            state_d = sspf_pkg::S_IDLE;
          end
        end
      end
      default: state_d = sspf_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/sspf_dp.sv =====
// Datapath: byte stores, pointers, link state and result register.
`timescale 1ns / 1ps
`default_nettype none

module sspf_dp #(
  parameter int unsigned FIFO_DEPTH = sspf_pkg::DEF_FIFO_DEPTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire sspf_pkg::in_item_t            in_data_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [sspf_pkg::BYTE_W-1:0]   cfg_wdata_i,
  input  wire sspf_pkg::ctrl_cmd_t           cmd_i,
  output sspf_pkg::dp_stat_t                 stat_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output sspf_pkg::out_item_t                out_data_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned BW    = sspf_pkg::BYTE_W;
  localparam int unsigned LW    = sspf_pkg::LEN_W;
  localparam int unsigned TW    = sspf_pkg::TYPE_W;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [BW-1:0] tx_mem [FIFO_DEPTH];
  logic [BW-1:0] rx_mem [FIFO_DEPTH];
  logic [BW-1:0] tx_rdata_q, rx_rdata_q;

  logic [PTR_W-1:0] tx_rd_ptr_q, tx_rd_ptr_d, tx_wr_ptr_q, tx_wr_ptr_d;
  logic [PTR_W-1:0] rx_rd_ptr_q, rx_rd_ptr_d, rx_wr_ptr_q, rx_wr_ptr_d;
  logic [CNT_W-1:0] tx_count_q, tx_count_d, rx_count_q, rx_count_d;
  sspf_pkg::mode_e  link_mode_q, link_mode_d;
  logic [LW-1:0]    link_rem_q, link_rem_d;
  logic [LW-1:0]    host_owed_q, host_owed_d;
  logic             tx_ready_q, tx_ready_d;
  logic [BW-1:0]    cmd_byte_q;
  logic [LW-1:0]    stream_rem_q, stream_rem_d;
  logic [TW-1:0]    hdr_type_q, hdr_type_d;
  logic [LW-1:0]    hdr_len_q, hdr_len_d;
  logic             out_valid_q, out_valid_d;
  sspf_pkg::in_item_t  item_q;
  sspf_pkg::out_item_t out_q, res;

  logic          tx_push, tx_pop, rx_push, rx_pop;
  logic [BW-1:0] tx_wdata, rx_wdata;
  logic          tx_full, rx_full;
  logic [LW-1:0] rx_hdr_len;
  logic [TW-1:0] rx_hdr_type;
  logic          rx_partial, tx_no_space;
  logic [LW-1:0] owed_dec, rem_dec;

  assign tx_full     = (tx_count_q == CNT_W'(FIFO_DEPTH));
  assign rx_full     = (rx_count_q == CNT_W'(FIFO_DEPTH));
  assign rx_hdr_len  = rx_rdata_q[LW-1:0];
  assign rx_hdr_type = rx_rdata_q[BW-1:LW];
  assign rx_partial  = (SUM_W'(rx_count_q) < (SUM_W'(rx_hdr_len) + 1'b1));
  assign tx_no_space = ((SUM_W'(tx_count_q) + SUM_W'(item_q.pkt_len_in) + 1'b1) >
                        SUM_W'(FIFO_DEPTH));
  assign owed_dec    = host_owed_q - 1'b1;
  assign rem_dec     = link_rem_q - 1'b1;

  assign stat_o.out_free     = !out_valid_q || out_ready_i;
  assign stat_o.stream_start = (item_q.opcode == sspf_pkg::OP_READ) &&
                               (rx_count_q != '0) && !rx_partial && (rx_hdr_len != '0);
  assign stat_o.stream_last  = (stream_rem_q == LW'(1));

  always_comb begin
    tx_push      = 1'b0;
    tx_pop       = 1'b0;
    rx_push      = 1'b0;
    rx_pop       = 1'b0;
    tx_wdata     = item_q.data_byte;
    rx_wdata     = item_q.mosi_byte;
    link_mode_d  = link_mode_q;
    link_rem_d   = link_rem_q;
    host_owed_d  = host_owed_q;
    tx_ready_d   = tx_ready_q;
    stream_rem_d = stream_rem_q;
    hdr_type_d   = hdr_type_q;
    hdr_len_d    = hdr_len_q;
    res          = '0;
    res.status   = sspf_pkg::ST_OK;
    res.last     = 1'b1;

    if (cmd_i.exec) begin
      unique case (item_q.opcode)
        sspf_pkg::OP_SPI: begin
          res.miso_byte = cmd_byte_q;
          if (link_mode_q == sspf_pkg::MODE_SEND) begin
            if (tx_count_q == '0 || link_rem_q == '0) begin
              link_mode_d = sspf_pkg::MODE_IDLE;
              link_rem_d  = '0;
            end else begin
              res.miso_byte = tx_rdata_q;
              tx_pop        = 1'b1;
              link_rem_d    = rem_dec;
              if (rem_dec == '0) link_mode_d = sspf_pkg::MODE_IDLE;
            end
          end else if (link_mode_q == sspf_pkg::MODE_RECV) begin
            rx_push        = !rx_full;
            res.rx_dropped = rx_full;
            if (link_rem_q == '0 || rem_dec == '0) begin
              link_rem_d  = '0;
              link_mode_d = sspf_pkg::MODE_IDLE;
            end else begin
              link_rem_d  = rem_dec;
            end
          end else if (item_q.mosi_byte == cmd_byte_q) begin
            link_mode_d = sspf_pkg::MODE_IDLE;
            if (tx_count_q == '0) begin
              tx_ready_d = 1'b0;
            end else if (tx_ready_q && host_owed_q == '0) begin
              // header goes out now, payload on the following transfers
              tx_pop        = 1'b1;
              res.miso_byte = tx_rdata_q;
              link_rem_d    = tx_rdata_q[LW-1:0];
              if (tx_rdata_q[LW-1:0] != '0) link_mode_d = sspf_pkg::MODE_SEND;
            end
          end else begin
            rx_push        = !rx_full;
            res.rx_dropped = rx_full;
            link_rem_d     = item_q.mosi_byte[LW-1:0];
            link_mode_d    = (item_q.mosi_byte[LW-1:0] != '0) ? sspf_pkg::MODE_RECV
                                                              : sspf_pkg::MODE_IDLE;
          end
        end
        sspf_pkg::OP_HDR: begin
          if (host_owed_q != '0 || tx_no_space) begin
            res.status = sspf_pkg::ST_REJECT;
          end else begin
            tx_push     = 1'b1;
            tx_wdata    = {item_q.pkt_type_in, item_q.pkt_len_in};
            host_owed_d = item_q.pkt_len_in;
            if (item_q.pkt_len_in == '0) tx_ready_d = 1'b1;
          end
        end
        sspf_pkg::OP_DATA: begin
          if (host_owed_q == '0 || tx_full) begin
            res.status = sspf_pkg::ST_REJECT;
          end else begin
            tx_push     = 1'b1;
            host_owed_d = owed_dec;
            if (owed_dec == '0) tx_ready_d = 1'b1;
          end
        end
        sspf_pkg::OP_READ: begin
          if (rx_count_q == '0) begin
            res.status = sspf_pkg::ST_EMPTY;
          end else if (rx_partial) begin
            res.status   = sspf_pkg::ST_PARTIAL;
            res.pkt_type = rx_hdr_type;
            res.pkt_len  = rx_hdr_len;
          end else begin
            rx_pop       = 1'b1;
            res.pkt_type = rx_hdr_type;
            res.pkt_len  = rx_hdr_len;
            res.last     = (rx_hdr_len == '0);
            hdr_type_d   = rx_hdr_type;
            hdr_len_d    = rx_hdr_len;
            stream_rem_d = rx_hdr_len;
          end
        end
        default: res.status = sspf_pkg::ST_REJECT;
      endcase
    end else if (cmd_i.stream) begin
      rx_pop            = 1'b1;
      res.pkt_type      = hdr_type_q;
      res.pkt_len       = hdr_len_q;
      res.rx_byte       = rx_rdata_q;
      res.rx_byte_valid = 1'b1;
      res.last          = (stream_rem_q == LW'(1));
      stream_rem_d      = stream_rem_q - 1'b1;
    end
  end

  always_comb begin
    tx_rd_ptr_d = tx_pop  ? ptr_next(tx_rd_ptr_q) : tx_rd_ptr_q;
    tx_wr_ptr_d = tx_push ? ptr_next(tx_wr_ptr_q) : tx_wr_ptr_q;
    rx_rd_ptr_d = rx_pop  ? ptr_next(rx_rd_ptr_q) : rx_rd_ptr_q;
    rx_wr_ptr_d = rx_push ? ptr_next(rx_wr_ptr_q) : rx_wr_ptr_q;
    priority if (tx_push)     tx_count_d = tx_count_q + 1'b1;
    else if (tx_pop)          tx_count_d = tx_count_q - 1'b1;
    else                      tx_count_d = tx_count_q;
    priority if (rx_push)     rx_count_d = rx_count_q + 1'b1;
    else if (rx_pop)          rx_count_d = rx_count_q - 1'b1;
    else                      rx_count_d = rx_count_q;
    if (cmd_i.exec || cmd_i.stream) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // read port addressed by the next pointer, so read data tracks the head
  always_ff @(posedge clk_i) begin
    if (tx_push) tx_mem[tx_wr_ptr_q] <= tx_wdata;
    tx_rdata_q <= tx_mem[tx_rd_ptr_d];
  end

  always_ff @(posedge clk_i) begin
    if (rx_push) rx_mem[rx_wr_ptr_q] <= rx_wdata;
    rx_rdata_q <= rx_mem[rx_rd_ptr_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_rd_ptr_q  <= '0;
      tx_wr_ptr_q  <= '0;
      tx_count_q   <= '0;
      rx_rd_ptr_q  <= '0;
      rx_wr_ptr_q  <= '0;
      rx_count_q   <= '0;
      link_mode_q  <= sspf_pkg::MODE_IDLE;
      link_rem_q   <= '0;
      host_owed_q  <= '0;
      tx_ready_q   <= 1'b0;
      cmd_byte_q   <= sspf_pkg::CMD_BYTE_RESET;
      stream_rem_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      tx_rd_ptr_q  <= tx_rd_ptr_d;
      tx_wr_ptr_q  <= tx_wr_ptr_d;
      tx_count_q   <= tx_count_d;
      rx_rd_ptr_q  <= rx_rd_ptr_d;
      rx_wr_ptr_q  <= rx_wr_ptr_d;
      rx_count_q   <= rx_count_d;
      link_mode_q  <= link_mode_d;
      link_rem_q   <= link_rem_d;
      host_owed_q  <= host_owed_d;
      tx_ready_q   <= tx_ready_d;
      if (cfg_we_i) cmd_byte_q <= cfg_wdata_i;
      stream_rem_q <= stream_rem_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_data_i;
    if (cmd_i.exec || cmd_i.stream) out_q <= res;
    hdr_type_q <= hdr_type_d;
    hdr_len_q  <= hdr_len_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
